// ===== hw/rtl/mpct_pkg.sv =====
package mpct_pkg;

  // coordinate storage width, range 8..16
  localparam int unsigned CoordBits = 16;

  // fixed field widths
  localparam int unsigned CursorW  = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // register map
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegScreenHeight = CfgIdxW'(1);

  // header byte bit positions
  localparam int unsigned AlignBit = 3;
  localparam int unsigned XSignBit = 4;
  localparam int unsigned YSignBit = 5;

  // text mode defaults used when a size register is zero
  localparam int unsigned DefaultMaxX = 79;
  localparam int unsigned DefaultMaxY = 24;
  localparam int unsigned DefaultMidX = 40;
  localparam int unsigned DefaultMidY = 12;

  typedef enum logic [0:0] {
    OpData     = 1'b0,
    OpRecenter = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    PhHeader = 3'b001,
    PhXByte  = 3'b010,
    PhYByte  = 3'b100
  } phase_e;

endpackage

// ===== hw/rtl/mpct_in_if.sv =====
interface mpct_in_if;
  import mpct_pkg::*;

  logic             valid;
  logic             ready;
  opcode_e          opcode;
  logic             aux_source;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output opcode, output aux_source, output data_byte,
                  input ready);
  modport sink   (input valid, input opcode, input aux_source, input data_byte,
                  output ready);
endinterface

// ===== hw/rtl/mpct_out_if.sv =====
interface mpct_out_if;
  import mpct_pkg::*;

  logic               valid;
  logic               ready;
  logic [CursorW-1:0] cursor_x;
  logic [CursorW-1:0] cursor_y;

  modport source (output valid, output cursor_x, output cursor_y, input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, output ready);
endinterface

// ===== hw/rtl/mpct_cfg_if.sv =====
interface mpct_cfg_if;
  import mpct_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/mouse_packet_cursor_tracker.sv =====
// mouse report cursor tracker
//
// in_i  : one byte-level item per transfer (opcode, aux_source, data_byte).
//         a data byte from the pointing device steps through the three-byte
//         report; a recenter item moves the cursor to mid-screen.
// out_o : one transfer of (cursor_x, cursor_y) each time a report completes.
// cfg_i : register writes, index 0 screen_width, index 1 screen_height; always ready,
//         the user writes it only while the block is idle; the block does not check.
//
// path: an item is held in the input register, then the add-and-clamp
// logic writes the cursor and the result register, which drives out_o
// once the third byte of a report leaves the input register.
// throughput: one item per cycle while no report-completing byte waits,
// set by the combinational add-and-clamp path between input register
// and result register.
// stall: the result register holds while out_o.ready is low; items that
// produce no result keep flowing, and a report-completing byte waits in
// the input register, at which point in_i.ready drops.
// reset: phase back to header, cursor at 0,0, sizes zero (80 by 25 text).
module mouse_packet_cursor_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  mpct_in_if.sink         in_i,
  mpct_out_if.source      out_o,
  mpct_cfg_if.sink        cfg_i
);
  import mpct_pkg::*;

  localparam int unsigned SumW = CoordBits + 2;
  localparam logic [SizeW:0] CoordCap =
    {(SizeW + 1 - CoordBits)'(0), {CoordBits{1'b1}}};

  // upper bound of a coordinate: size-1, or the text default, capped
  function automatic logic [CoordBits-1:0] limit_of(logic [SizeW-1:0] size,
                                                    logic [SizeW-1:0] dflt);
    logic [SizeW:0] m;
    m = (size != '0) ? ({1'b0, size} - (SizeW + 1)'(1)) : {1'b0, dflt};
    if (m > CoordCap) m = CoordCap;
    return m[CoordBits-1:0];
  endfunction

  // mid-screen point, or the text default, capped
  function automatic logic [CoordBits-1:0] centre_of(logic [SizeW-1:0] size,
                                                     logic [SizeW-1:0] dflt);
    logic [SizeW:0] c;
    c = (size != '0) ? {2'b00, size[SizeW-1:1]} : {1'b0, dflt};
    if (c > CoordCap) c = CoordCap;
    return c[CoordBits-1:0];
  endfunction

  function automatic logic [CoordBits-1:0] clamp_coord(logic signed [SumW-1:0] v,
                                                       logic [CoordBits-1:0] hi);
    logic [CoordBits-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({2'b00, hi})) r = hi;
    else r = v[CoordBits-1:0];
    return r;
  endfunction

  // configuration
  logic [SizeW-1:0] width_q, height_q;

  // input register
  logic             s1_valid_q, s1_valid_d;
  opcode_e          s1_opcode_q;
  logic             s1_aux_q;
  logic [ByteW-1:0] s1_byte_q;

  // report state and cursor
  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     hdr_q, hdr_d;
  logic [ByteW-1:0]     xbyte_q, xbyte_d;
  logic [CoordBits-1:0] pos_x_q, pos_x_d;
  logic [CoordBits-1:0] pos_y_q, pos_y_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [CoordBits-1:0] out_x_q, out_y_q;

  logic                    in_xfer;
  logic                    is_dev_byte;
  logic                    completes;
  logic                    s1_fire;
  logic signed [ByteW:0]   dx, dy;
  logic signed [SumW-1:0]  nx, ny;
  logic [CoordBits-1:0]    new_x, new_y;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegScreenWidth)  width_q  <= cfg_i.data[SizeW-1:0];
      if (cfg_i.index == RegScreenHeight) height_q <= cfg_i.data[SizeW-1:0];
    end
  end

  // a report-completing byte needs room in the result register
  assign is_dev_byte = (s1_opcode_q == OpData) && s1_aux_q;
  assign completes   = is_dev_byte && (phase_q == PhYByte);
  assign s1_fire     = s1_valid_q && (!completes || !out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_fire;
  assign in_xfer     = in_i.valid && in_i.ready;

  assign s1_valid_d = in_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_opcode_q <= in_i.opcode;
      s1_aux_q    <= in_i.aux_source;
      s1_byte_q   <= in_i.data_byte;
    end
  end

  // 9-bit signed deltas, sign bits from the header
  assign dx = $signed({hdr_q[XSignBit], xbyte_q});
  assign dy = $signed({hdr_q[YSignBit], s1_byte_q});
  // screen y grows downwards, so the y movement is subtracted
  assign nx = $signed({2'b00, pos_x_q}) + SumW'(dx);
  assign ny = $signed({2'b00, pos_y_q}) - SumW'(dy);
  assign new_x = clamp_coord(nx, limit_of(width_q, SizeW'(DefaultMaxX)));
  assign new_y = clamp_coord(ny, limit_of(height_q, SizeW'(DefaultMaxY)));

  always_comb begin
    phase_d = phase_q;
    hdr_d   = hdr_q;
    xbyte_d = xbyte_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (s1_fire) begin
      if (s1_opcode_q == OpRecenter) begin
        // phase is left alone
        pos_x_d = centre_of(width_q, SizeW'(DefaultMidX));
        pos_y_d = centre_of(height_q, SizeW'(DefaultMidY));
      end else if (s1_aux_q) begin
        unique case (phase_q)
          PhXByte: begin
            xbyte_d = s1_byte_q;
            phase_d = PhYByte;
          end
          PhYByte: begin
            pos_x_d = new_x;
            pos_y_d = new_y;
            phase_d = PhHeader;
          end
          default: begin
            // header only starts a report when the alignment bit is set
            hdr_d   = s1_byte_q;
            phase_d = s1_byte_q[AlignBit] ? PhXByte : PhHeader;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      hdr_q   <= '0;
      xbyte_q <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      xbyte_q <= xbyte_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

  // result register, refilled in the same cycle it is taken
  assign out_valid_d = (s1_fire && completes) ? 1'b1 :
                       (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && completes) begin
      out_x_q <= new_x;
      out_y_q <= new_y;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.cursor_x = CursorW'(out_x_q);
  assign out_o.cursor_y = CursorW'(out_y_q);

`ifndef SYNTHESIS
  // input only stalls behind a full result register and a waiting third byte
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && completes && !out_o.ready))
    else $error("input stalled without a blocked report");

  // a new result only follows a completed report
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && completes))
    else $error("result appeared without a completed report");

  // recenter leaves the report phase untouched
  a_recenter_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_opcode_q == OpRecenter) |=> $stable(phase_q))
    else $error("recenter changed the report phase");

  // a completed report always returns to the header phase
  a_report_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && completes) |=> (phase_q == PhHeader))
    else $error("phase did not wrap after a report");
`endif

endmodule

// ===== tb/tb_mouse_packet_cursor_tracker.sv =====
module tb_mouse_packet_cursor_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import mpct_pkg::*;

  localparam int ClkHalf     = 10;
  localparam int ResetCycles = 10;
  // margin for the pipe to settle once no result is owed
  localparam int SettleCycles = 6;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 500000;
  localparam int RandomItems  = 1250;
  localparam int NumSettings  = 9;
  localparam int MaxPrinted   = 40;

  typedef struct packed {
    logic [CursorW-1:0] x;
    logic [CursorW-1:0] y;
  } cursor_t;

  // cursor predictor plus the queue of positions still owed by the block
  class cursor_scoreboard;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    phase_e           next_byte;
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] x_move;
    int               pos_x;
    int               pos_y;
    int               coord_top;
    cursor_t          owed_q[$];
    int               mismatches;
    int               checked;
    int               accepted;
    int               recentres;
    int               ignored;

    function new();
      width      = '0;
      height     = '0;
      next_byte  = PhHeader;
      header     = '0;
      x_move     = '0;
      pos_x      = 0;
      pos_y      = 0;
      coord_top  = (1 << CoordBits) - 1;
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
      recentres  = 0;
      ignored    = 0;
    endfunction

    function void set_size(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx == RegScreenWidth) width = value;
      else if (idx == RegScreenHeight) height = value;
    endfunction

    // highest legal coordinate for a size, zero meaning the text default
    function int coord_ceiling(logic [SizeW-1:0] size, int text_max);
      int m;
      m = (size != '0) ? int'(size) - 1 : text_max;
      return (m > coord_top) ? coord_top : m;
    endfunction

    function int mid_point(logic [SizeW-1:0] size, int text_mid);
      int c;
      c = (size != '0) ? int'(size) / 2 : text_mid;
      return (c > coord_top) ? coord_top : c;
    endfunction

    function int clamp_to(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    function void note_item(opcode_e op, logic aux, logic [ByteW-1:0] b);
      int      dx;
      int      dy;
      cursor_t pos;
      accepted++;
      if (op == OpRecenter) begin
        // phase and partial report survive a recentre
        pos_x = mid_point(width, DefaultMidX);
        pos_y = mid_point(height, DefaultMidY);
        recentres++;
        return;
      end
      if (!aux) begin
        ignored++;
        return;
      end
      case (next_byte)
        PhXByte: begin
          x_move    = b;
          next_byte = PhYByte;
        end
        PhYByte: begin
          dx = int'(x_move) - (header[XSignBit] ? (1 << ByteW) : 0);
          dy = int'(b) - (header[YSignBit] ? (1 << ByteW) : 0);
          // screen y grows downwards
          pos_x = clamp_to(pos_x + dx, coord_ceiling(width, DefaultMaxX));
          pos_y = clamp_to(pos_y - dy, coord_ceiling(height, DefaultMaxY));
          pos.x = pos_x[CursorW-1:0];
          pos.y = pos_y[CursorW-1:0];
          owed_q.push_back(pos);
          next_byte = PhHeader;
        end
        default: begin
          header    = b;
          next_byte = b[AlignBit] ? PhXByte : PhHeader;
        end
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("[%0t] mismatch %0d: %s", $time, mismatches, msg);
    endtask

    task check_result(logic [CursorW-1:0] x, logic [CursorW-1:0] y);
      cursor_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d", x, y));
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (x !== want.x) report($sformatf("cursor_x got %0d want %0d", x, want.x));
      if (y !== want.y) report($sformatf("cursor_y got %0d want %0d", y, want.y));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  mpct_in_if  in_if ();
  mpct_out_if out_if ();
  mpct_cfg_if cfg_if ();

  mouse_packet_cursor_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cursor_scoreboard sb;

  // sender pacing
  int gap_max;
  int burst_left;
  bit offering;
  // receiver pacing, set by the main sequence
  int stall_pct;
  bit hold_req;
  int cycles;
  int settings_done;

  always begin
    clk_i = 1'b0;
    #(ClkHalf);
    clk_i = 1'b1;
    #(ClkHalf);
  end

  // receiver: random stalls at the phase's rate, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // result side: values seen here are the ones before the edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        sb.check_result(out_if.cursor_x, out_if.cursor_y);
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[%0t] watchdog expired, %0d results still owed", $time, sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

  // one input transfer, then maybe a gap once the burst runs out
  task automatic send_item(opcode_e op, logic aux, logic [ByteW-1:0] b);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.aux_source <= aux;
    in_if.data_byte  <= b;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(op, aux, b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_foreign();
    send_item(OpData, 1'b0, ByteW'($urandom));
  endtask

  // stop offering and let every owed result come out, then let the pipe settle
  task automatic drain_results();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_sizes(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= RegScreenWidth;
    cfg_if.data  <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_size(RegScreenWidth, w);
    cfg_if.index <= RegScreenHeight;
    cfg_if.data  <= h;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_size(RegScreenHeight, h);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    settings_done++;
  endtask

  // movement byte biased towards the extremes of the 9-bit delta
  function automatic logic [ByteW-1:0] pick_move();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h01;
      default: return ByteW'($urandom);
    endcase
  endfunction

  task automatic pick_setting(int idx, output logic [SizeW-1:0] w, output logic [SizeW-1:0] h,
                              output int gaps, output int stalls, output bit hold);
    hold = 1'b0;
    case (idx)
      0: begin w = 16'd1;     h = 16'd1;     gaps = 3; stalls = 30; end
      1: begin w = 16'hFFFF;  h = 16'hFFFF;  gaps = 0; stalls = 0;  hold = 1'b1; end
      2: begin w = 16'd640;   h = 16'd480;   gaps = 5; stalls = 50; end
      3: begin w = 16'd0;     h = 16'd0;     gaps = 2; stalls = 20; end
      4: begin w = 16'd2;     h = 16'd3;     gaps = 8; stalls = 70; end
      5: begin w = 16'hFFFF;  h = 16'd0;     gaps = 1; stalls = 10; end
      6: begin w = 16'd0;     h = 16'hFFFF;  gaps = 4; stalls = 40; end
      7: begin w = 16'd300;   h = 16'd200;   gaps = 0; stalls = 60; end
      default: begin
        w = SizeW'($urandom);
        h = SizeW'($urandom_range(0, 600));
        gaps = 6; stalls = 25;
      end
    endcase
  endtask

  // mostly well-formed reports with random content, the rest noise and broken reports
  task automatic random_items(int n);
    int               count;
    int               r;
    logic [ByteW-1:0] head;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        head = ByteW'($urandom);
        head[AlignBit] = 1'b1;
        send_item(OpData, 1'b1, head);
        if ($urandom_range(0, 9) == 0) send_foreign();
        send_item(OpData, 1'b1, pick_move());
        if ($urandom_range(0, 9) == 0) send_foreign();
        if ($urandom_range(0, 29) == 0) begin
          // recentre in the middle of a report
          send_item(OpRecenter, 1'($urandom), ByteW'($urandom));
          count++;
        end
        send_item(OpData, 1'b1, pick_move());
        count += 3;
      end else if (r < 86) begin
        send_item(OpRecenter, 1'($urandom), ByteW'($urandom));
        count++;
      end else if (r < 92) begin
        send_foreign();
      end else if (r < 96) begin
        head = ByteW'($urandom);
        head[AlignBit] = 1'b0;
        send_item(OpData, 1'b1, head);
        count++;
      end else begin
        // truncated report: the next header lands as its third byte
        head = ByteW'($urandom);
        head[AlignBit] = 1'b1;
        send_item(OpData, 1'b1, head);
        send_item(OpData, 1'b1, ByteW'($urandom));
        count += 2;
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
  endtask

  initial begin
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
    int               gaps;
    int               stalls;
    bit               hold;

    sb = new();
    gap_max       = 1;
    burst_left    = 4;
    offering      = 1'b0;
    stall_pct     = 20;
    hold_req      = 1'b0;
    settings_done = 0;

    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OpData;
    in_if.aux_source <= 1'b0;
    in_if.data_byte  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= RegScreenWidth;
    cfg_if.data      <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part on the 80 by 25 text defaults
    send_item(OpRecenter, 1'b0, 8'h00);   // centre of the text screen
    send_item(OpData, 1'b0, 8'h08);       // foreign byte that looks like a header
    send_item(OpData, 1'b1, 8'h37);       // header without alignment bit
    send_item(OpData, 1'b1, 8'h08);       // small positive move
    send_item(OpData, 1'b1, 8'h05);
    send_item(OpData, 1'b1, 8'h03);
    send_item(OpData, 1'b1, 8'hC8);       // overflow bits set, clamps right and top
    send_item(OpData, 1'b1, 8'hFF);
    send_item(OpData, 1'b1, 8'hFF);
    send_item(OpData, 1'b1, 8'h38);       // both signs, largest negative deltas
    send_item(OpData, 1'b1, 8'h00);
    send_item(OpData, 1'b1, 8'h00);
    send_item(OpData, 1'b1, 8'h18);       // recentre and foreign byte inside a report
    send_item(OpRecenter, 1'b1, 8'hFF);
    send_item(OpData, 1'b1, 8'h80);
    send_item(OpData, 1'b0, 8'hFF);
    send_item(OpData, 1'b1, 8'h7F);
    send_item(OpData, 1'b1, 8'h38);       // minus one on both axes
    send_item(OpData, 1'b1, 8'hFF);
    send_item(OpData, 1'b1, 8'hFF);
    send_item(OpData, 1'b1, 8'h08);       // zero move
    send_item(OpData, 1'b1, 8'h00);
    send_item(OpData, 1'b1, 8'h00);
    drain_results();

    for (int p = 0; p < NumSettings; p++) begin
      pick_setting(p, w, h, gaps, stalls, hold);
      write_sizes(w, h);
      gap_max   = gaps;
      stall_pct = stalls;
      // long receiver hold-off while the sender keeps offering back to back
      if (hold) hold_req = 1'b1;
      random_items(RandomItems / NumSettings);
      drain_results();
    end

    $display("covered %0d transfers in: %0d recentres, %0d foreign bytes, %0d size settings",
             sb.accepted, sb.recentres, sb.ignored, settings_done);
    $display("checked %0d cursor results, %0d mismatches, %0d cycles",
             sb.checked, sb.mismatches, cycles);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mpct_pkg.sv
hw/rtl/mpct_in_if.sv
hw/rtl/mpct_out_if.sv
hw/rtl/mpct_cfg_if.sv
hw/rtl/mouse_packet_cursor_tracker.sv
tb/tb_mouse_packet_cursor_tracker.sv
